/* src/isl_pkg.sv */
// ---------------------------------------------------------------------------
// isl_pkg
// Shared sizes, operation and status codes, and control types of the
// indexed shift list.
// ---------------------------------------------------------------------------
`default_nettype none

package isl_pkg;

   localparam int DEPTH   = 64;
   localparam int WIDTH   = 32;

   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);

   localparam int FUNC_W  = 3;
   localparam int POS_W   = 7;
   localparam int VALUE_W = 32;
   localparam int FIELD_W = 7;
   localparam int STAT_W  = 2;

   localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH_BACK  = 3'd0,
      FUNC_PUSH_FRONT = 3'd1,
      FUNC_POP_BACK   = 3'd2,
      FUNC_POP_FRONT  = 3'd3,
      FUNC_INSERT     = 3'd4,
      FUNC_ERASE      = 3'd5,
      FUNC_READ       = 3'd6
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic             open;
      logic             close;
      logic [IDX_W-1:0] at;
      logic [WIDTH-1:0] value;
   } cell_ctl_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      status_type       status;
      logic             read_hit;
   } result_type;

endpackage

`default_nettype wire

/* src/isl_cell.sv */
// ---------------------------------------------------------------------------
// isl_cell
// One slot of the list: holds, loads, or takes a neighbor's word.
// ---------------------------------------------------------------------------
`default_nettype none

module isl_cell
   import isl_pkg::*;
(
   input  wire logic             clock,
   input  wire cell_ctl_type     ctl,
   input  wire logic [IDX_W-1:0] slot,
   input  wire logic [WIDTH-1:0] left_data,
   input  wire logic [WIDTH-1:0] right_data,
   output      logic [WIDTH-1:0] data
);

   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      priority if (ctl.open && (slot > ctl.at)) begin
         data_in = left_data;
      end else if (ctl.open && (slot == ctl.at)) begin
         data_in = ctl.value;
      end else if (ctl.close && (slot >= ctl.at)) begin
         data_in = right_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

/* src/isl_ctrl.sv */
// ---------------------------------------------------------------------------
// isl_ctrl
// Operation decode, range checks and entry count of the indexed shift list.
// ---------------------------------------------------------------------------
`default_nettype none

module isl_ctrl
   import isl_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [FUNC_W-1:0] func,
   input  wire logic [POS_W-1:0] position,
   input  wire logic [WIDTH-1:0] value,
   output      cell_ctl_type     ctl,
   output      result_type       result,
   output      logic [CNT_W-1:0] count
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             open_c;
   logic             close_c;
   logic [IDX_W-1:0] at_c;
   status_type       status_c;
   logic             read_hit_c;
   logic [CMP_W-1:0] pos_x;
   logic [CMP_W-1:0] cnt_x;
   logic             is_full;
   logic             is_empty;

   assign pos_x    = CMP_W'(position);
   assign cnt_x    = CMP_W'(count_ff);
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   always_comb begin
      open_c     = 1'b0;
      close_c    = 1'b0;
      at_c       = '0;
      status_c   = STAT_OK;
      read_hit_c = 1'b0;
      count_in   = count_ff;
      unique case (func)
         FUNC_PUSH_BACK, FUNC_PUSH_FRONT: begin
            if (is_full) begin
               status_c = STAT_FULL;
            end else begin
               open_c   = 1'b1;
               at_c     = (func == FUNC_PUSH_BACK) ? IDX_W'(count_ff) : '0;
               count_in = count_ff + CNT_W'(1);
            end
         end
         FUNC_POP_BACK, FUNC_POP_FRONT: begin
            if (is_empty) begin
               status_c = STAT_EMPTY;
            end else begin
               close_c  = (func == FUNC_POP_FRONT);
               count_in = count_ff - CNT_W'(1);
            end
         end
         FUNC_INSERT: begin
            if (pos_x > cnt_x) begin
               status_c = STAT_RANGE;
            end else if (is_full) begin
               status_c = STAT_FULL;
            end else begin
               open_c   = 1'b1;
               at_c     = IDX_W'(position);
               count_in = count_ff + CNT_W'(1);
            end
         end
         FUNC_ERASE, FUNC_READ: begin
            if (is_empty) begin
               status_c = STAT_EMPTY;
            end else if (pos_x >= cnt_x) begin
               status_c = STAT_RANGE;
            end else if (func == FUNC_ERASE) begin
               close_c  = 1'b1;
               at_c     = IDX_W'(position);
               count_in = count_ff - CNT_W'(1);
            end else begin
               read_hit_c = 1'b1;
            end
         end
         default: begin
            status_c = STAT_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   assign ctl.open        = open_c & accept;
   assign ctl.close       = close_c & accept;
   assign ctl.at          = at_c;
   assign ctl.value       = value;
   assign result.count    = count_in;
   assign result.status   = status_c;
   assign result.read_hit = read_hit_c;
   assign count           = count_ff;

endmodule

`default_nettype wire

/* src/indexed_shift_list_unit.sv */
// A result beat is registered in the cycle after its request beat is accepted.
// Throughput: one request beat per cycle unless output stalls; every cell of
// the row shifts in the same cycle, and a new beat is taken while the result
// register drains. Reset clears the entry count and the result valid; cell
// contents are left as they are and only slots below the count are ever read.
// ---------------------------------------------------------------------------
// indexed_shift_list_unit
// Ordered list held in a row of shifting cells with push, pop, insert,
// erase and read by index.
// ---------------------------------------------------------------------------
`default_nettype none

module indexed_shift_list_unit
   import isl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // func[2:0], position[9:3], item_value[41:10], zero fill[47:42]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // read_value[31:0], count[38:32], free_slots[45:39], status[47:46]
   output      logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic                  req_accept;
   logic [FUNC_W-1:0]     req_func;
   logic [POS_W-1:0]      req_position;
   logic [VALUE_W-1:0]    req_item_value;
   cell_ctl_type          cell_ctl;
   result_type            result;
   logic [CNT_W-1:0]      list_count;
   logic [WIDTH-1:0]      cell_data [DEPTH];
   logic [VALUE_W-1:0]    read_value;
   logic [CNT_W-1:0]      free_slots;
   logic                  rsp_tvalid_ff;
   logic                  rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_in;

   assign req_func       = req_tdata[2:0];
   assign req_position   = req_tdata[9:3];
   assign req_item_value = req_tdata[41:10];

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   isl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .func     (req_func),
      .position (req_position),
      .value    (WIDTH'(req_item_value)),
      .ctl      (cell_ctl),
      .result   (result),
      .count    (list_count)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WIDTH-1:0] left_data;
      logic [WIDTH-1:0] right_data;
      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid_l
         assign left_data = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_mid_r
         assign right_data = cell_data[i+1];
      end
      isl_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .slot       (IDX_W'(i)),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i])
      );
   end

   assign read_value = result.read_hit ? VALUE_W'(cell_data[req_position[IDX_W-1:0]]) : '0;
   assign free_slots = CNT_W'(DEPTH) - result.count;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      priority if (req_accept) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {result.status, FIELD_W'(free_slots), FIELD_W'(result.count),
                          read_value};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      list_count <= CNT_W'(DEPTH))
      else $error("entry count above capacity");

   a_accept_gives_beat: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid_ff)
      else $error("accepted request without result beat");

   a_count_free_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> (rsp_tdata_ff[38:32] + rsp_tdata_ff[45:39] == FIELD_W'(DEPTH)))
      else $error("count and free slots do not add to capacity");

   a_fail_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (result.status != STAT_OK)) |=> $stable(list_count))
      else $error("failed operation changed the list");

   a_read_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && (rsp_tdata_ff[47:46] != STAT_OK)) |-> (rsp_tdata_ff[31:0] == '0))
      else $error("read value on a failed operation");

endmodule

`default_nettype wire
